### hw/rtl/spr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the stepper pulse-rate ramp block.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int PERIOD_BITS = 16;
    localparam int CLK_W       = 29;
    localparam int RATE_W      = 20;
    localparam int PSC_W       = 16;
    localparam int PROD_W      = RATE_W + PSC_W + 1;
    localparam int DVS_W       = (PERIOD_BITS + RATE_W + 1 > PROD_W) ?
                                 (PERIOD_BITS + RATE_W + 1) : PROD_W;
    localparam int CMP_W       = ((CLK_W > PERIOD_BITS) ? CLK_W : PERIOD_BITS) + 1;
    localparam int CNT_W       = $clog2(CLK_W + 1);

    localparam logic [PERIOD_BITS-1:0] PER_LIM = '1;
    localparam logic [PSC_W-1:0]       PSC_MAX = 16'hFFFF;

    localparam logic [CLK_W-1:0]  RST_TIMER_CLK = 29'd84000000;
    localparam logic [RATE_W-1:0] RST_MIN_RATE  = 20'd10000;
    localparam logic [RATE_W-1:0] RST_MAX_RATE  = 20'd200000;
    localparam logic [RATE_W-1:0] RST_RATE_STEP = 20'd10000;

    typedef enum logic [1:0] {
        CMD_SET      = 2'd0,
        CMD_START    = 2'd1,
        CMD_INCREASE = 2'd2,
        CMD_STOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_TIMER_CLK = 2'd0,
        CFG_MIN_RATE  = 2'd1,
        CFG_MAX_RATE  = 2'd2,
        CFG_RATE_STEP = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD1,
        S_DIV1,
        S_MUL,
        S_DIV2,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [RATE_W-1:0] rate_request_hz;
        logic              turn_direction;
    } t_in_item;

    typedef struct packed {
        logic [15:0]       prescale_value;
        logic [15:0]       period_value;
        logic [14:0]       compare_value;
        logic [RATE_W-1:0] current_rate_hz;
        logic              pulses_on;
        logic              driver_enable;
        logic              direction_out;
        logic              rate_error;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [CLK_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [CLK_W-1:0]  quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

### hw/rtl/spr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spr_pkg::t_div_req i_req,
    output spr_pkg::t_div_rsp      o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [spr_pkg::CNT_W-1:0]       r_cnt;
    logic [spr_pkg::CLK_W-1:0]       r_rem;
    logic [spr_pkg::CLK_W-1:0]       r_quo;
    logic [spr_pkg::DVS_W-1:0]       r_dvs;

    logic [spr_pkg::CLK_W:0]         w_trial;
    logic                            w_fit;
    logic [spr_pkg::CLK_W:0]         w_diff;

    assign w_trial = {r_rem, r_quo[spr_pkg::CLK_W-1]};
    assign w_fit   = spr_pkg::DVS_W'(w_trial) >= r_dvs;
    assign w_diff  = w_trial - r_dvs[spr_pkg::CLK_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == spr_pkg::CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= spr_pkg::CNT_W'(spr_pkg::CLK_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - spr_pkg::CNT_W'(1);
                if (r_cnt == spr_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[spr_pkg::CLK_W-1:0] : w_trial[spr_pkg::CLK_W-1:0];
            r_quo <= {r_quo[spr_pkg::CLK_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

### hw/rtl/stepper_pwm_rate_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_pwm_rate_ramp
// Step-pulse rate generator for one stepper axis: timer prescaler and
// period search with a linear rate ramp.
// ----------------------------------------------------------------------------
// Each item carries one command (set rate, start, increase, stop) and gives
// exactly one result item with the timer settings and status after it. A
// command that programs a rate goes through a preparation step, then one
// shared divider producing one quotient bit per cycle runs twice, first for
// the prescaler clk / ((2^PERIOD_BITS + 1) * f), then for the period
// clk / (f * (psc + 1)) - 1. The first run is loaded from its own load
// state and the second from the multiply state between the runs; each run
// shifts out all CLK_W quotient bits and ends with a done strobe, and a
// final commit step follows. A command that programs nothing (rejected
// rate, increase at or above the maximum) goes from preparation straight to
// commit. One item is in work at a time and the block is ready again the
// cycle after the commit. The result sits in an output register, so the
// next item is accepted while it waits to be taken; a result still waiting
// holds the next one in its commit cycle. Configuration writes take effect
// at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module stepper_pwm_rate_ramp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command items
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire spr_pkg::t_in_item          i_in_item,
    // result items
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output spr_pkg::t_out_item              o_out_item,
    // configuration writes
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_index,
    input  wire logic [spr_pkg::CLK_W-1:0]  i_cfg_wdata
);

    // configuration registers
    logic [spr_pkg::CLK_W-1:0]       r_clk_hz;
    logic [spr_pkg::RATE_W-1:0]      r_min_rate;
    logic [spr_pkg::RATE_W-1:0]      r_max_rate;
    logic [spr_pkg::RATE_W-1:0]      r_rate_step;

    // architectural state, also the visible result
    logic [spr_pkg::RATE_W-1:0]      r_rate_now;
    logic [spr_pkg::PSC_W-1:0]       r_prescale;
    logic [spr_pkg::PERIOD_BITS-1:0] r_period;
    logic                            r_running;
    logic                            r_enable;
    logic                            r_direction;
    logic                            r_err_out;
    logic                            r_out_valid;

    // sequencer and working registers
    spr_pkg::t_state                 r_state;
    spr_pkg::t_state                 n_state;
    spr_pkg::t_cmd                   r_cmd;
    logic [spr_pkg::RATE_W-1:0]      r_req;
    logic                            r_dir;
    logic [spr_pkg::RATE_W-1:0]      r_f;
    logic                            r_prog;
    logic                            r_err;
    logic [spr_pkg::PSC_W-1:0]       r_psc_new;
    logic [spr_pkg::PERIOD_BITS-1:0] r_per_new;

    spr_pkg::t_div_req               w_div_req;
    spr_pkg::t_div_rsp               w_div_rsp;

    logic [spr_pkg::RATE_W:0]        w_sum;
    logic [spr_pkg::RATE_W-1:0]      w_inc_rate;
    logic [spr_pkg::RATE_W-1:0]      w_f;
    logic                            w_want;
    logic                            w_reject;
    logic [spr_pkg::PSC_W:0]         w_psc_p1;
    logic [spr_pkg::PROD_W-1:0]      w_prod;
    logic [spr_pkg::CLK_W-1:0]       w_q2m1;
    logic                            w_per_sat;
    logic                            w_commit;
    logic                            w_accept;
    logic [31:0]                     w_per_ext;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_commit = (r_state == spr_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz    <= spr_pkg::RST_TIMER_CLK;
            r_min_rate  <= spr_pkg::RST_MIN_RATE;
            r_max_rate  <= spr_pkg::RST_MAX_RATE;
            r_rate_step <= spr_pkg::RST_RATE_STEP;
        end else if (i_cfg_we) begin
            case (spr_pkg::t_cfg_idx'(i_cfg_index))
                spr_pkg::CFG_TIMER_CLK: r_clk_hz    <= i_cfg_wdata;
                spr_pkg::CFG_MIN_RATE:  r_min_rate  <= i_cfg_wdata[spr_pkg::RATE_W-1:0];
                spr_pkg::CFG_MAX_RATE:  r_max_rate  <= i_cfg_wdata[spr_pkg::RATE_W-1:0];
                spr_pkg::CFG_RATE_STEP: r_rate_step <= i_cfg_wdata[spr_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- rate selection for the latched command ----------------
    // increase: add the step, clamp at the maximum, skip when already there
    assign w_sum      = {1'b0, r_rate_now} + {1'b0, r_rate_step};
    assign w_inc_rate = (w_sum > {1'b0, r_max_rate}) ? r_max_rate
                                                     : w_sum[spr_pkg::RATE_W-1:0];

    always_comb begin
        w_f    = r_min_rate;
        w_want = 1'b1;
        case (r_cmd)
            spr_pkg::CMD_SET:      w_f = r_req;
            spr_pkg::CMD_INCREASE: begin
                w_f    = w_inc_rate;
                w_want = r_rate_now < r_max_rate;
            end
            default:               w_f = r_min_rate;
        endcase
    end

    // zero rate or rate above the timer clock is refused
    assign w_reject = (w_f == '0) || (spr_pkg::CLK_W'(w_f) > r_clk_hz);

    // ---------------- shared divider ----------------
    assign w_psc_p1 = {1'b0, r_psc_new} + (spr_pkg::PSC_W + 1)'(1);
    assign w_prod   = spr_pkg::PROD_W'(r_f) * spr_pkg::PROD_W'(w_psc_p1);

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_clk_hz;
        // (2^PERIOD_BITS + 1) * f for the prescaler search
        w_div_req.divisor  = (spr_pkg::DVS_W'(r_f) << spr_pkg::PERIOD_BITS)
                             + spr_pkg::DVS_W'(r_f);
        if (r_state == spr_pkg::S_LOAD1) begin
            w_div_req.start = 1'b1;
        end else if (r_state == spr_pkg::S_MUL) begin
            // f * (psc + 1); the divider's divisor register follows the multiply
            w_div_req.start   = 1'b1;
            w_div_req.divisor = spr_pkg::DVS_W'(w_prod);
        end
    end

    spr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // period = quotient - 1, saturated (a zero quotient wraps to the limit)
    assign w_q2m1    = w_div_rsp.quotient - spr_pkg::CLK_W'(1);
    assign w_per_sat = (w_div_rsp.quotient == '0)
                    || (spr_pkg::CMP_W'(w_q2m1) > spr_pkg::CMP_W'(spr_pkg::PER_LIM));

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            spr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = spr_pkg::S_PREP;
                end
            end
            spr_pkg::S_PREP: begin
                n_state = (w_want && !w_reject) ? spr_pkg::S_LOAD1 : spr_pkg::S_DONE;
            end
            spr_pkg::S_LOAD1: n_state = spr_pkg::S_DIV1;
            spr_pkg::S_DIV1: begin
                if (w_div_rsp.done) begin
                    n_state = spr_pkg::S_MUL;
                end
            end
            spr_pkg::S_MUL:   n_state = spr_pkg::S_DIV2;
            spr_pkg::S_DIV2: begin
                if (w_div_rsp.done) begin
                    n_state = spr_pkg::S_DONE;
                end
            end
            spr_pkg::S_DONE: begin
                if (w_commit) begin
                    n_state = spr_pkg::S_IDLE;
                end
            end
            default: n_state = spr_pkg::S_IDLE;
        endcase
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_item.command;
            r_req <= i_in_item.rate_request_hz;
            r_dir <= i_in_item.turn_direction;
        end
        if (r_state == spr_pkg::S_PREP) begin
            r_f    <= w_f;
            r_prog <= w_want && !w_reject;
            r_err  <= w_want && w_reject;
        end
        if ((r_state == spr_pkg::S_DIV1) && w_div_rsp.done) begin
            r_psc_new <= (w_div_rsp.quotient > spr_pkg::CLK_W'(spr_pkg::PSC_MAX))
                       ? spr_pkg::PSC_MAX : w_div_rsp.quotient[spr_pkg::PSC_W-1:0];
        end
        if ((r_state == spr_pkg::S_DIV2) && w_div_rsp.done) begin
            r_per_new <= w_per_sat ? spr_pkg::PER_LIM
                                   : w_q2m1[spr_pkg::PERIOD_BITS-1:0];
        end
    end

    // ---------------- commit and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_now  <= '0;
            r_prescale  <= '0;
            r_period    <= '0;
            r_running   <= 1'b0;
            r_enable    <= 1'b0;
            r_direction <= 1'b0;
            r_err_out   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit) begin
                r_err_out <= r_err;
                if (r_prog) begin
                    r_rate_now <= r_f;
                    r_prescale <= r_psc_new;
                    r_period   <= r_per_new;
                end
                // stop turns pulses off even after reprogramming the minimum
                if (r_cmd == spr_pkg::CMD_STOP) begin
                    r_running <= 1'b0;
                end else if (r_prog) begin
                    r_running <= 1'b1;
                end
                if (r_cmd == spr_pkg::CMD_START) begin
                    r_direction <= r_dir;
                    r_enable    <= 1'b1;
                end else if (r_cmd == spr_pkg::CMD_STOP) begin
                    r_enable    <= 1'b0;
                end
            end
        end
    end

    assign w_per_ext   = 32'(r_period);
    assign o_out_valid = r_out_valid;

    assign o_out_item.prescale_value  = r_prescale;
    assign o_out_item.period_value    = w_per_ext[15:0];
    assign o_out_item.compare_value   = w_per_ext[15:1];
    assign o_out_item.current_rate_hz = r_rate_now;
    assign o_out_item.pulses_on       = r_running;
    assign o_out_item.driver_enable   = r_enable;
    assign o_out_item.direction_out   = r_direction;
    assign o_out_item.rate_error      = r_err_out;

`ifndef SYNTHESIS
    // a waiting result must not be overwritten by the next command
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(r_rate_now) && $stable(r_period)
                                          && $stable(r_err_out)))
        else $error("state changed while result waited");

    // a refused rate leaves the programmed rate alone
    a_err_keeps_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_err) |=> ($stable(r_rate_now) && $stable(r_prescale)))
        else $error("refused rate changed timer settings");

    // the divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> ((r_state == spr_pkg::S_DIV1) || (r_state == spr_pkg::S_DIV2)))
        else $error("divider done outside a divide state");

    // an accepted item always starts its preparation step
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == spr_pkg::S_PREP))
        else $error("accepted item not started");
`endif

endmodule
`default_nettype wire

### tb/stepper_pwm_rate_ramp_tb.sv
// ----------------------------------------------------------------------------
// stepper_pwm_rate_ramp_tb
// Self-checking bench for the step-pulse rate generator. A scripted opening
// run under the reset settings is followed by several rate-register setups
// (extremes first, then random ones), each driving a mix of set, start,
// ramp and stop commands. Every accepted command is run through a timer
// settings predictor and each result item is compared field by field.
// ----------------------------------------------------------------------------
module stepper_pwm_rate_ramp_tb;

    localparam int ITEMS_PER_PHASE = 230;
    localparam int NUM_PHASES      = 8;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int MAX_RATE_FIELD  = 1000000;
    localparam int NUM_SCRIPT      = 21;

    // one scripted command, with a hand-typed result where it is obvious
    typedef struct packed {
        spr_pkg::t_cmd              cmd;
        logic [spr_pkg::RATE_W-1:0] rate;
        logic                       dir;
        logic                       typed;
        spr_pkg::t_out_item         want;
    } t_script_row;

    // dut-facing signals; the ones the bench drives are known from time zero
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    spr_pkg::t_in_item          in_item   = '0;
    logic                       out_ready = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [1:0]                 cfg_index = spr_pkg::CFG_TIMER_CLK;
    logic [spr_pkg::CLK_W-1:0]  cfg_wdata = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    spr_pkg::t_out_item         o_out_item;

    // mirror of the rate registers
    logic [spr_pkg::CLK_W-1:0]  cfg_timer_clk = spr_pkg::RST_TIMER_CLK;
    logic [spr_pkg::RATE_W-1:0] cfg_min_rate  = spr_pkg::RST_MIN_RATE;
    logic [spr_pkg::RATE_W-1:0] cfg_max_rate  = spr_pkg::RST_MAX_RATE;
    logic [spr_pkg::RATE_W-1:0] cfg_rate_step = spr_pkg::RST_RATE_STEP;

    // predicted timer and pin state
    logic [spr_pkg::RATE_W-1:0] rate_now     = '0;
    logic [15:0]                prescale_now = '0;
    logic [31:0]                period_now   = '0;
    logic                       running_now  = 1'b0;
    logic                       enable_now   = 1'b0;
    logic                       dir_now      = 1'b0;

    spr_pkg::t_out_item settings_due[$];
    int                 mismatch_count = 0;
    int                 stall_cycles   = 0;
    int                 tx_idle_pct    = 29;
    int                 rx_stall_pct   = 29;

    // scripted opening under reset settings (84 MHz timer, 10k min, 200k max, 10k step)
    t_script_row script_rows [NUM_SCRIPT] = '{
        // zero rate right after reset: rejected, everything still zero
        '{spr_pkg::CMD_SET,      20'd0,       1'b0, 1'b1,
          {16'd0, 16'd0,    15'd0,    20'd0,       1'b0, 1'b0, 1'b0, 1'b1}},
        // ramp from zero lands on one step
        '{spr_pkg::CMD_INCREASE, 20'd12345,   1'b1, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd10000,   1'b0, 1'b1,
          {16'd0, 16'd8399, 15'd4199, 20'd10000,   1'b1, 1'b0, 1'b0, 1'b0}},
        '{spr_pkg::CMD_START,    20'd777,     1'b1, 1'b1,
          {16'd0, 16'd8399, 15'd4199, 20'd10000,   1'b1, 1'b1, 1'b1, 1'b0}},
        // top of the rate field
        '{spr_pkg::CMD_SET,      20'd1000000, 1'b0, 1'b1,
          {16'd0, 16'd83,   15'd41,   20'd1000000, 1'b1, 1'b1, 1'b1, 1'b0}},
        // ramp while already above the clamp: nothing moves, no error
        '{spr_pkg::CMD_INCREASE, 20'd0,       1'b0, 1'b1,
          {16'd0, 16'd83,   15'd41,   20'd1000000, 1'b1, 1'b1, 1'b1, 1'b0}},
        // rejected rate keeps the timer as it was
        '{spr_pkg::CMD_SET,      20'd0,       1'b1, 1'b1,
          {16'd0, 16'd83,   15'd41,   20'd1000000, 1'b1, 1'b1, 1'b1, 1'b1}},
        // stop reprograms the minimum, drops pulses and enable, keeps direction
        '{spr_pkg::CMD_STOP,     20'd55,      1'b0, 1'b1,
          {16'd0, 16'd8399, 15'd4199, 20'd10000,   1'b0, 1'b0, 1'b1, 1'b0}},
        '{spr_pkg::CMD_SET,      20'd1,       1'b0, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd2,       1'b1, 1'b0, '0},
        '{spr_pkg::CMD_INCREASE, 20'd0,       1'b0, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd199999,  1'b0, 1'b0, '0},
        // step overshoots the maximum and gets clamped
        '{spr_pkg::CMD_INCREASE, 20'd0,       1'b0, 1'b0, '0},
        '{spr_pkg::CMD_INCREASE, 20'd0,       1'b1, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd524288,  1'b0, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd699050,  1'b1, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd349525,  1'b0, 1'b0, '0},
        '{spr_pkg::CMD_START,    20'd1048575, 1'b0, 1'b0, '0},
        '{spr_pkg::CMD_STOP,     20'd1,       1'b1, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd1282,    1'b0, 1'b0, '0},
        '{spr_pkg::CMD_SET,      20'd999999,  1'b1, 1'b0, '0}
    };

    stepper_pwm_rate_ramp u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // search the smallest prescaler that lets the period fit, then load the timer;
    // returns 1 when the rate is zero or above the timer clock
    function automatic logic program_timer(input longint unsigned f);
        longint unsigned clk_hz;
        longint unsigned per_lim;
        longint unsigned psc;
        longint unsigned per;
        clk_hz  = 64'(cfg_timer_clk);
        per_lim = (64'd1 << spr_pkg::PERIOD_BITS) - 64'd1;
        if (f == 0 || f > clk_hz)
            return 1'b1;
        psc = clk_hz / ((per_lim + 64'd2) * f);
        if (psc > 64'(spr_pkg::PSC_MAX))
            psc = 64'(spr_pkg::PSC_MAX);
        per = clk_hz / (f * (psc + 64'd1)) - 64'd1;
        if (per > per_lim)
            per = per_lim;
        prescale_now = psc[15:0];
        period_now   = per[31:0];
        rate_now     = f[spr_pkg::RATE_W-1:0];
        running_now  = 1'b1;
        return 1'b0;
    endfunction

    // timer settings and pin levels after one command
    function automatic spr_pkg::t_out_item next_timer_settings(input spr_pkg::t_in_item it);
        spr_pkg::t_out_item r;
        logic               rejected;
        longint unsigned    ramp_hz;
        rejected = 1'b0;
        case (it.command)
            spr_pkg::CMD_SET: begin
                rejected = program_timer(64'(it.rate_request_hz));
            end
            spr_pkg::CMD_START: begin
                // direction and enable latch even if the minimum is rejected
                rejected   = program_timer(64'(cfg_min_rate));
                dir_now    = it.turn_direction;
                enable_now = 1'b1;
            end
            spr_pkg::CMD_INCREASE: begin
                if (rate_now < cfg_max_rate) begin
                    ramp_hz = 64'(rate_now) + 64'(cfg_rate_step);
                    if (ramp_hz > 64'(cfg_max_rate))
                        ramp_hz = 64'(cfg_max_rate);
                    rejected = program_timer(ramp_hz);
                end
            end
            spr_pkg::CMD_STOP: begin
                rejected    = program_timer(64'(cfg_min_rate));
                running_now = 1'b0;
                enable_now  = 1'b0;
            end
            default: ;
        endcase
        r.prescale_value  = prescale_now;
        r.period_value    = period_now[15:0];
        r.compare_value   = period_now[15:1];
        r.current_rate_hz = rate_now;
        r.pulses_on       = running_now;
        r.driver_enable   = enable_now;
        r.direction_out   = dir_now;
        r.rate_error      = rejected;
        return r;
    endfunction

    // random command: ramps most often, rates biased to zero, the clock edge and powers of two
    function automatic spr_pkg::t_in_item random_cmd();
        spr_pkg::t_in_item it;
        int                pick;
        int                r;
        pick = $urandom_range(99);
        if (pick < 25)
            it.command = spr_pkg::CMD_SET;
        else if (pick < 40)
            it.command = spr_pkg::CMD_START;
        else if (pick < 85)
            it.command = spr_pkg::CMD_INCREASE;
        else
            it.command = spr_pkg::CMD_STOP;
        it.turn_direction = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 8) begin
            r = 0;
        end else if (pick < 20 && cfg_timer_clk <= spr_pkg::CLK_W'(MAX_RATE_FIELD)) begin
            // just below, at and just above the timer clock
            r = int'(cfg_timer_clk) + int'($urandom_range(4)) - 2;
            if (r < 0)
                r = 0;
            if (r > MAX_RATE_FIELD)
                r = MAX_RATE_FIELD;
        end else if (pick < 40) begin
            r = $urandom_range(1000);
        end else if (pick < 55) begin
            r = 1 << $urandom_range(19);
        end else begin
            r = $urandom_range(MAX_RATE_FIELD);
        end
        it.rate_request_hz = spr_pkg::RATE_W'(r);
        return it;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %0h got %0h", field, $time, want, got);
    endtask

    // hand one command over, then record what it should produce
    task automatic send_cmd(input spr_pkg::t_in_item it, input logic typed,
                            input spr_pkg::t_out_item want);
        spr_pkg::t_out_item predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
        predicted = next_timer_settings(it);
        settings_due.push_back(typed ? want : predicted);
    endtask

    // hold the sender off until every pending result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (settings_due.size() != 0)
            @(posedge clk);
    endtask

    // rewrite all four rate registers, one per cycle
    task automatic write_rate_regs(input logic [spr_pkg::CLK_W-1:0]  clk_hz,
                                   input logic [spr_pkg::RATE_W-1:0] min_hz,
                                   input logic [spr_pkg::RATE_W-1:0] max_hz,
                                   input logic [spr_pkg::RATE_W-1:0] step_hz);
        cfg_we    <= 1'b1;
        cfg_index <= spr_pkg::CFG_TIMER_CLK;
        cfg_wdata <= clk_hz;
        @(posedge clk);
        cfg_index <= spr_pkg::CFG_MIN_RATE;
        cfg_wdata <= spr_pkg::CLK_W'(min_hz);
        @(posedge clk);
        cfg_index <= spr_pkg::CFG_MAX_RATE;
        cfg_wdata <= spr_pkg::CLK_W'(max_hz);
        @(posedge clk);
        cfg_index <= spr_pkg::CFG_RATE_STEP;
        cfg_wdata <= spr_pkg::CLK_W'(step_hz);
        @(posedge clk);
        cfg_we        <= 1'b0;
        cfg_timer_clk = clk_hz;
        cfg_min_rate  = min_hz;
        cfg_max_rate  = max_hz;
        cfg_rate_step = step_hz;
    endtask

    // result side back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // result checker: every taken result against the oldest prediction
    always @(posedge clk) begin : check_results
        spr_pkg::t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            if (settings_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result at %0t with nothing pending: %h", $time, o_out_item);
            end else begin
                want = settings_due.pop_front();
                if (o_out_item.prescale_value !== want.prescale_value)
                    flag_field("prescale_value", 32'(want.prescale_value),
                               32'(o_out_item.prescale_value));
                if (o_out_item.period_value !== want.period_value)
                    flag_field("period_value", 32'(want.period_value),
                               32'(o_out_item.period_value));
                if (o_out_item.compare_value !== want.compare_value)
                    flag_field("compare_value", 32'(want.compare_value),
                               32'(o_out_item.compare_value));
                if (o_out_item.current_rate_hz !== want.current_rate_hz)
                    flag_field("current_rate_hz", 32'(want.current_rate_hz),
                               32'(o_out_item.current_rate_hz));
                if (o_out_item.pulses_on !== want.pulses_on)
                    flag_field("pulses_on", 32'(want.pulses_on),
                               32'(o_out_item.pulses_on));
                if (o_out_item.driver_enable !== want.driver_enable)
                    flag_field("driver_enable", 32'(want.driver_enable),
                               32'(o_out_item.driver_enable));
                if (o_out_item.direction_out !== want.direction_out)
                    flag_field("direction_out", 32'(want.direction_out),
                               32'(o_out_item.direction_out));
                if (o_out_item.rate_error !== want.rate_error)
                    flag_field("rate_error", 32'(want.rate_error),
                               32'(o_out_item.rate_error));
            end
        end
    end

    // watchdog: too long with no item moving on either side
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        spr_pkg::t_in_item         it;
        int                        k;
        int                        ph;
        logic [spr_pkg::CLK_W-1:0] clk_pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // scripted opening under the reset settings
        for (k = 0; k < NUM_SCRIPT; k++) begin
            it.command         = script_rows[k].cmd;
            it.rate_request_hz = script_rows[k].rate;
            it.turn_direction  = script_rows[k].dir;
            send_cmd(it, script_rows[k].typed, script_rows[k].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                // rate registers change only with the block idle
                drain_results();
                case (ph)
                    1: write_rate_regs(29'd400000000, 20'd1, 20'd1000000, 20'd1000000);
                    2: write_rate_regs(29'd1, 20'd1, 20'd1, 20'd0);
                    // minimum above the clock: start and stop are rejected
                    3: write_rate_regs(29'd5000, 20'd10000, 20'd1000000, 20'd0);
                    // clamp below the minimum
                    4: write_rate_regs(29'd1000000, 20'd1000000, 20'd1, 20'd1);
                    default: begin
                        case ($urandom_range(2))
                            0: clk_pick = spr_pkg::CLK_W'($urandom_range(400000000, 1));
                            1: clk_pick = spr_pkg::CLK_W'($urandom_range(2000000, 1000));
                            default: clk_pick = spr_pkg::CLK_W'($urandom_range(5000, 1));
                        endcase
                        write_rate_regs(clk_pick,
                                        spr_pkg::RATE_W'($urandom_range(50000, 1)),
                                        spr_pkg::RATE_W'($urandom_range(MAX_RATE_FIELD, 1)),
                                        spr_pkg::RATE_W'($urandom_range(100000)));
                    end
                endcase
            end
            // phase 1 runs flat out on both sides
            tx_idle_pct  = (ph == 1) ? 0 : 29;
            rx_stall_pct = (ph == 1) ? 0 : 29;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 0 && k == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && settings_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### stepper_pwm_rate_ramp.f
hw/rtl/spr_pkg.sv
hw/rtl/spr_div.sv
hw/rtl/stepper_pwm_rate_ramp.sv
tb/stepper_pwm_rate_ramp_tb.sv
